### rtl/core/fhm_pkg.sv
package fhm_pkg;

   // Defaults for the top-level parameters.
   localparam int LogDepthDefault = 64;
   localparam int MaxPartsDefault = 4;

   // Error codes at or above this count are rejected.
   localparam int ErrKinds = 8;

   localparam logic [23:0] ACTION_WORD_RESET = 24'h924924;

   // Request kinds.
   localparam logic [1:0] ACT_RAISE      = 2'd0;
   localparam logic [1:0] ACT_READ_EVENT = 2'd1;
   localparam logic [1:0] ACT_READ_STATS = 2'd2;

   // Result status codes.
   localparam logic [2:0] STS_OK     = 3'd0;
   localparam logic [2:0] STS_NOCFG  = 3'd1;
   localparam logic [2:0] STS_PARAM  = 3'd2;
   localparam logic [2:0] STS_ACCESS = 3'd3;
   localparam logic [2:0] STS_RANGE  = 3'd4;

   // Responses that are carried out.
   localparam logic [2:0] RESP_LOG  = 3'd0;
   localparam logic [2:0] RESP_IDLE = 3'd1;
   localparam logic [2:0] RESP_COLD = 3'd3;
   localparam logic [2:0] RESP_SAFE = 3'd4;

   // Configuration register indexes.
   localparam logic [3:0] CSR_CONFIGURED  = 4'd0;
   localparam logic [3:0] CSR_PART_COUNT  = 4'd1;
   localparam logic [3:0] CSR_MAINT_PART  = 4'd2;
   localparam logic [3:0] CSR_MODULE_WORD = 4'd3;
   localparam logic [3:0] CSR_PART0_WORD  = 4'd4;
   localparam logic [3:0] CSR_PART1_WORD  = 4'd5;
   localparam logic [3:0] CSR_PART2_WORD  = 4'd6;
   localparam logic [3:0] CSR_PART3_WORD  = 4'd7;

   typedef struct packed {
      logic [1:0]  action;
      logic        caller_is_kernel;
      logic [1:0]  caller_part;
      logic        target_is_module;
      logic [2:0]  target_part;
      logic [3:0]  err_code;
      logic [31:0] detail;
      logic [7:0]  event_index;
      logic [63:0] timestamp_us;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] event_time;
      logic        event_is_module;
      logic [2:0]  event_part;
      logic [3:0]  event_err;
      logic [2:0]  event_response;
      logic [31:0] event_detail;
      logic [6:0]  log_count;
      logic [31:0] lost_count;
      logic [2:0]  applied_response;
      logic        safe_state;
      logic [3:0]  safe_code;
   } rsp_item_type;

   typedef struct packed {
      logic             configured;
      logic [2:0]       partition_count;
      logic [1:0]       maintenance_partition;
      logic [23:0]      module_action_word;
      logic [3:0][23:0] part_action_word;
   } cfg_type;

   typedef struct packed {
      logic [63:0] time_us;
      logic        is_module;
      logic [1:0]  part;
      logic [3:0]  err;
      logic [2:0]  response;
      logic [31:0] detail;
   } log_entry_type;

   // Three bits per error code; codes past the top of the word read as zero.
   function automatic logic [2:0] lookup_response(input logic [23:0] word,
                                                   input logic [3:0] err);
      logic [5:0]  sh;
      logic [47:0] shifted;
      sh      = {2'b00, err} + {1'b0, err, 1'b0};
      shifted = {24'd0, word} >> sh;
      return shifted[2:0];
   endfunction

endpackage

### rtl/core/fault_health_monitor_unit.sv
// Fault health monitor: a taken request is registered and moves the block into the execute
// state, where the result is worked out; the result and its strobe are registered from there.
// busy is high for the one execute cycle, so a new request is taken only once the block is idle.
// The receiver cannot stall the result; it is shown for exactly one cycle.
// Synchronous reset clears the counters, partition modes and configuration;
// the event log memory is not cleared and entries are readable only once written.
module fault_health_monitor_unit #(
   parameter int LogDepth = fhm_pkg::LogDepthDefault,
   parameter int MaxParts = fhm_pkg::MaxPartsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fhm_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output fhm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_index,
   input  logic [23:0]           csr_wdata
);
   import fhm_pkg::*;

   localparam int AddrWidth  = (LogDepth > 1) ? $clog2(LogDepth) : 1;
   localparam int CountWidth = $clog2(LogDepth + 1);
   localparam int PartWidth  = (MaxParts > 1) ? $clog2(MaxParts) : 1;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type              state_ff, state_in;
   req_item_type           req_ff;
   rsp_item_type           rsp_ff, rsp_in;
   logic                   strobe_ff, strobe_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [31:0]            lost_ff, lost_in;
   logic [1:0]             mode_ff [MaxParts];
   logic [1:0]             mode_in [MaxParts];

   cfg_type                cfg;
   logic                   accept;
   logic                   log_wr;
   log_entry_type          log_wdata;
   log_entry_type          log_rdata;

   logic [2:0]             resp;
   logic                   log_has_room;

   assign busy       = (state_ff == S_EXEC);
   assign accept     = start && !busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   fhm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The read is issued at every accepting edge, so for an event request the
   // entry is ready in the execute cycle. Raises write in that cycle.
   fhm_log_mem #(
      .Depth     (LogDepth),
      .AddrWidth (AddrWidth)
   ) u_log_mem (
      .clock   (clock),
      .wr_en   (log_wr),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (log_wdata),
      .rd_en   (accept),
      .rd_addr (req_item.event_index[AddrWidth-1:0]),
      .rd_data (log_rdata)
   );

   assign log_has_room = (count_ff < CountWidth'(LogDepth));

   // The response word is chosen by the target: the module word, or the
   // action word of the partition the fault belongs to.
   always_comb begin
      if (req_ff.target_is_module) begin
         resp = lookup_response(cfg.module_action_word, req_ff.err_code);
      end else begin
         resp = lookup_response(cfg.part_action_word[req_ff.target_part[1:0]],
                                req_ff.err_code);
      end
   end

   always_comb begin
      log_wdata.time_us   = req_ff.timestamp_us;
      log_wdata.is_module = req_ff.target_is_module;
      log_wdata.part      = req_ff.target_is_module ? 2'd0 : req_ff.target_part[1:0];
      log_wdata.err       = req_ff.err_code;
      log_wdata.response  = resp;
      log_wdata.detail    = req_ff.detail;
   end

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      count_in  = count_ff;
      lost_in   = lost_ff;
      mode_in   = mode_ff;
      log_wr    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_IDLE;
            strobe_in = 1'b1;
            rsp_in    = '0;

            case (req_ff.action)
               ACT_RAISE: begin
                  if (!cfg.configured) begin
                     // Without a configuration every raise forces safe state.
                     rsp_in.status           = STS_NOCFG;
                     rsp_in.applied_response = RESP_SAFE;
                     rsp_in.safe_state       = 1'b1;
                     rsp_in.safe_code        = req_ff.err_code;
                  end else if ({1'b0, req_ff.err_code} >= 5'(ErrKinds)) begin
                     rsp_in.status = STS_PARAM;
                  end else if (!req_ff.caller_is_kernel &&
                               (req_ff.target_is_module ||
                                {1'b0, req_ff.caller_part} != req_ff.target_part)) begin
                     rsp_in.status = STS_ACCESS;
                  end else if (!req_ff.target_is_module &&
                               (req_ff.target_part >= cfg.partition_count ||
                                {1'b0, req_ff.target_part} >= 4'(MaxParts))) begin
                     rsp_in.status = STS_RANGE;
                  end else begin
                     rsp_in.status = STS_OK;
                     // The log keeps the first events; later ones are only
                     // counted, and that count stops at its maximum.
                     if (log_has_room) begin
                        log_wr   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end else if (lost_ff != 32'hFFFF_FFFF) begin
                        lost_in = lost_ff + 32'd1;
                     end
                     // Responses above safe state are logged as they are but
                     // carried out as safe state. Module faults change no mode.
                     if (resp inside {[RESP_IDLE:RESP_COLD]}) begin
                        rsp_in.applied_response = resp;
                        if (!req_ff.target_is_module) begin
                           mode_in[req_ff.target_part[PartWidth-1:0]] = resp[1:0];
                        end
                     end else if (resp >= RESP_SAFE) begin
                        rsp_in.applied_response = RESP_SAFE;
                        rsp_in.safe_state       = 1'b1;
                        rsp_in.safe_code        = req_ff.err_code;
                     end else begin
                        rsp_in.applied_response = RESP_LOG;
                     end
                  end
               end
               ACT_READ_EVENT: begin
                  if (!cfg.configured) begin
                     rsp_in.status = STS_PARAM;
                  end else if (!req_ff.caller_is_kernel &&
                               req_ff.caller_part != cfg.maintenance_partition) begin
                     rsp_in.status = STS_ACCESS;
                  end else if ({1'b0, req_ff.event_index} >= 9'(count_ff)) begin
                     rsp_in.status = STS_RANGE;
                  end else begin
                     rsp_in.status          = STS_OK;
                     rsp_in.event_time      = log_rdata.time_us;
                     rsp_in.event_is_module = log_rdata.is_module;
                     rsp_in.event_part      = {1'b0, log_rdata.part};
                     rsp_in.event_err       = log_rdata.err;
                     rsp_in.event_response  = log_rdata.response;
                     rsp_in.event_detail    = log_rdata.detail;
                  end
               end
               ACT_READ_STATS: begin
                  rsp_in.status = STS_OK;
               end
               default: begin
                  rsp_in.status = STS_PARAM;
               end
            endcase

            // Every result carries the counts as they stand after this request.
            rsp_in.log_count  = 7'(count_in);
            rsp_in.lost_count = lost_in;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
         lost_ff   <= '0;
         for (int i = 0; i < MaxParts; i++) begin
            mode_ff[i] <= 2'd0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
         lost_ff   <= lost_in;
         mode_ff   <= mode_in;
      end
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_item;
      end
   end

endmodule

### rtl/core/fhm_csr.sv
module fhm_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [3:0]       csr_index,
   input  logic [23:0]      csr_wdata,
   output fhm_pkg::cfg_type cfg
);
   import fhm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CONFIGURED:  cfg_in.configured = csr_wdata[0];
            CSR_PART_COUNT:  cfg_in.partition_count = csr_wdata[2:0];
            CSR_MAINT_PART:  cfg_in.maintenance_partition = csr_wdata[1:0];
            CSR_MODULE_WORD: cfg_in.module_action_word = csr_wdata;
            CSR_PART0_WORD:  cfg_in.part_action_word[0] = csr_wdata;
            CSR_PART1_WORD:  cfg_in.part_action_word[1] = csr_wdata;
            CSR_PART2_WORD:  cfg_in.part_action_word[2] = csr_wdata;
            CSR_PART3_WORD:  cfg_in.part_action_word[3] = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.configured            <= 1'b0;
         cfg_ff.partition_count       <= 3'd0;
         cfg_ff.maintenance_partition <= 2'd0;
         cfg_ff.module_action_word    <= ACTION_WORD_RESET;
         cfg_ff.part_action_word      <= {4{ACTION_WORD_RESET}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/fhm_log_mem.sv
module fhm_log_mem #(
   parameter int Depth = fhm_pkg::LogDepthDefault,
   parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AddrWidth-1:0]   wr_addr,
   input  fhm_pkg::log_entry_type wr_data,
   input  logic                   rd_en,
   input  logic [AddrWidth-1:0]   rd_addr,
   output fhm_pkg::log_entry_type rd_data
);
   import fhm_pkg::*;

   log_entry_type mem [Depth];
   log_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/fhm_checker.sv
module fhm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input fhm_pkg::rsp_item_type rsp_item
);
   import fhm_pkg::*;

   // A taken request always produces its result once the execute state is over.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result did not follow an accepted request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_idle_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while a result is shown");

   a_safe_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.safe_state) |->
         (rsp_item.safe_code == 4'd0 && rsp_item.applied_response != RESP_SAFE))
      else $error("safe code or safe response without safe state");

endmodule

bind fault_health_monitor_unit fhm_checker u_fhm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

### tb/fault_monitor_checker.sv
`timescale 1ns / 100ps

module fault_monitor_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  fhm_pkg::req_item_type req_item,
   input  logic                  rsp_strobe,
   input  fhm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [3:0]            csr_index,
   input  logic [23:0]           csr_wdata,
   output int                    failures,
   output int                    pending,
   output int                    checked
);

   import fhm_pkg::*;

   localparam int LogSlots = LogDepthDefault;
   localparam int PartSlots = MaxPartsDefault;

   typedef struct packed {
      logic        is_module;
      logic [1:0]  part;
      logic [3:0]  err;
      logic [2:0]  response;
      logic [31:0] detail;
   } fault_record_type;

   logic             cfg_configured;
   logic [2:0]       cfg_part_count;
   logic [1:0]       cfg_maint_part;
   logic [23:0]      cfg_module_word;
   logic [23:0]      cfg_part_word [4];

   logic [63:0]      fault_stamp [LogSlots];
   fault_record_type fault_record [LogSlots];
   logic [6:0]       logged_total;
   logic [31:0]      dropped_total;
   logic [1:0]       part_mode [PartSlots];

   rsp_item_type     expected_replies [$];
   rsp_item_type     oldest_reply;
   string            bad_fields;
   int               miss_count = 0;
   int               checked_count = 0;

   // Works out the result of one request and advances the log and modes.
   function automatic rsp_item_type resolve_request(input req_item_type r);
      rsp_item_type     o;
      logic [23:0]      word;
      logic [2:0]       resp;
      fault_record_type rec;
      o = '0;
      case (r.action)
         ACT_RAISE: begin
            if (!cfg_configured) begin
               o.status           = STS_NOCFG;
               o.applied_response = RESP_SAFE;
               o.safe_state       = 1'b1;
               o.safe_code        = r.err_code;
            end else if (r.err_code >= ErrKinds) begin
               o.status = STS_PARAM;
            end else if (!r.caller_is_kernel &&
                         (r.target_is_module || {1'b0, r.caller_part} != r.target_part)) begin
               o.status = STS_ACCESS;
            end else if (!r.target_is_module &&
                         (r.target_part >= cfg_part_count || r.target_part >= PartSlots)) begin
               o.status = STS_RANGE;
            end else begin
               word = r.target_is_module ? cfg_module_word : cfg_part_word[r.target_part[1:0]];
               resp = word[3 * r.err_code +: 3];
               if (logged_total < LogSlots) begin
                  rec.is_module = r.target_is_module;
                  rec.part      = r.target_is_module ? 2'd0 : r.target_part[1:0];
                  rec.err       = r.err_code;
                  rec.response  = resp;
                  rec.detail    = r.detail;
                  fault_stamp[logged_total[5:0]]  = r.timestamp_us;
                  fault_record[logged_total[5:0]] = rec;
                  logged_total++;
               end else if (dropped_total != '1) begin
                  dropped_total++;
               end
               if (resp >= RESP_IDLE && resp <= RESP_COLD) begin
                  if (!r.target_is_module) part_mode[r.target_part[1:0]] = resp[1:0];
                  o.applied_response = resp;
               end else if (resp >= RESP_SAFE) begin
                  o.applied_response = RESP_SAFE;
                  o.safe_state       = 1'b1;
                  o.safe_code        = r.err_code;
               end
               o.status = STS_OK;
            end
         end
         ACT_READ_EVENT: begin
            if (!cfg_configured) begin
               o.status = STS_PARAM;
            end else if (!r.caller_is_kernel && r.caller_part != cfg_maint_part) begin
               o.status = STS_ACCESS;
            end else if (r.event_index >= logged_total) begin
               o.status = STS_RANGE;
            end else begin
               rec = fault_record[r.event_index[5:0]];
               o.status          = STS_OK;
               o.event_time      = fault_stamp[r.event_index[5:0]];
               o.event_is_module = rec.is_module;
               o.event_part      = {1'b0, rec.part};
               o.event_err       = rec.err;
               o.event_response  = rec.response;
               o.event_detail    = rec.detail;
            end
         end
         ACT_READ_STATS: o.status = STS_OK;
         default: o.status = STS_PARAM;
      endcase
      o.log_count  = logged_total;
      o.lost_count = dropped_total;
      return o;
   endfunction

   function automatic string differing_fields(input rsp_item_type e, input rsp_item_type a);
      string s;
      s = "";
      if (e.status !== a.status) s = {s, " status"};
      if (e.event_time !== a.event_time) s = {s, " event_time"};
      if (e.event_is_module !== a.event_is_module) s = {s, " event_is_module"};
      if (e.event_part !== a.event_part) s = {s, " event_part"};
      if (e.event_err !== a.event_err) s = {s, " event_err"};
      if (e.event_response !== a.event_response) s = {s, " event_response"};
      if (e.event_detail !== a.event_detail) s = {s, " event_detail"};
      if (e.log_count !== a.log_count) s = {s, " log_count"};
      if (e.lost_count !== a.lost_count) s = {s, " lost_count"};
      if (e.applied_response !== a.applied_response) s = {s, " applied_response"};
      if (e.safe_state !== a.safe_state) s = {s, " safe_state"};
      if (e.safe_code !== a.safe_code) s = {s, " safe_code"};
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_configured  = 1'b0;
         cfg_part_count  = '0;
         cfg_maint_part  = '0;
         cfg_module_word = ACTION_WORD_RESET;
         for (int i = 0; i < 4; i++) cfg_part_word[i] = ACTION_WORD_RESET;
         for (int i = 0; i < PartSlots; i++) part_mode[i] = '0;
         logged_total  = '0;
         dropped_total = '0;
         expected_replies.delete();
      end else begin
         // Results are checked before a new request is queued on the same edge.
         if (rsp_strobe === 1'b1) begin
            if (expected_replies.size() == 0) begin
               miss_count++;
               if (miss_count <= 10)
                  $display("Result beat %h arrived with nothing outstanding", rsp_item);
            end else begin
               oldest_reply = expected_replies.pop_front();
               checked_count++;
               bad_fields = differing_fields(oldest_reply, rsp_item);
               if (bad_fields != "") begin
                  miss_count++;
                  if (miss_count <= 10)
                     $display("Result %0d wrong in%s: expected %h, got %h",
                              checked_count, bad_fields, oldest_reply, rsp_item);
               end
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_CONFIGURED:  cfg_configured  = csr_wdata[0];
               CSR_PART_COUNT:  cfg_part_count  = csr_wdata[2:0];
               CSR_MAINT_PART:  cfg_maint_part  = csr_wdata[1:0];
               CSR_MODULE_WORD: cfg_module_word = csr_wdata;
               CSR_PART0_WORD:  cfg_part_word[0] = csr_wdata;
               CSR_PART1_WORD:  cfg_part_word[1] = csr_wdata;
               CSR_PART2_WORD:  cfg_part_word[2] = csr_wdata;
               CSR_PART3_WORD:  cfg_part_word[3] = csr_wdata;
               default: ;
            endcase
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_replies.push_back(resolve_request(req_item));
      end
      failures <= miss_count;
      checked  <= checked_count;
      pending  <= expected_replies.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

   import fhm_pkg::*;

   // Action code 3 is not defined by the block and must be refused.
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   // Generous cycle ceiling for about 1650 requests, the idle gaps and the settling pauses.
   localparam int CycleLimit = 100000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         csr_valid;
   logic         csr_ready;
   logic [3:0]   csr_index;
   logic [23:0]  csr_wdata;

   int failures;
   int pending;
   int checked;

   // Shadow of the settings in force, so that random requests can be shaped
   // to get past the rights and range checks most of the time.
   int         cur_parts = 0;
   logic [1:0] cur_maint = '0;
   bit         steady = 1'b0;

   int cycle_count = 0;
   int settings_used = 0;
   int raise_count = 0;
   int read_count = 0;
   int stats_count = 0;
   int unknown_count = 0;

   fault_health_monitor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // The checker watches every channel, predicts each result and counts
   // mismatches; this module only drives the block and gives the verdict.
   fault_monitor_checker monitor_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // A hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // One configuration beat. Every task here is entered just after a rising
   // edge, so valid stays high across back-to-back writes and is only
   // lowered by the caller once the whole group has gone through.
   task automatic write_reg(input logic [3:0] index, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == CSR_PART_COUNT) cur_parts = int'(value[2:0]);
      if (index == CSR_MAINT_PART) cur_maint = value[1:0];
   endtask

   task automatic program_all(input logic configured, input logic [2:0] parts,
                              input logic [1:0] maint, input logic [23:0] module_word,
                              input logic [23:0] word0, input logic [23:0] word1,
                              input logic [23:0] word2, input logic [23:0] word3);
      write_reg(CSR_CONFIGURED, {23'd0, configured});
      write_reg(CSR_PART_COUNT, {21'd0, parts});
      write_reg(CSR_MAINT_PART, {22'd0, maint});
      write_reg(CSR_MODULE_WORD, module_word);
      write_reg(CSR_PART0_WORD, word0);
      write_reg(CSR_PART1_WORD, word1);
      write_reg(CSR_PART2_WORD, word2);
      write_reg(CSR_PART3_WORD, word3);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Hands one request to the block. Start is held until the beat is taken,
   // which happens on the first edge that finds busy low. Now and then the
   // request is held back first, with start low; since busy rises and falls
   // with each request, those gaps land on both phases of the block's work.
   task automatic send_request(input req_item_type r);
      if (!steady && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
      case (r.action)
         ACT_RAISE:      raise_count++;
         ACT_READ_EVENT: read_count++;
         ACT_READ_STATS: stats_count++;
         default:        unknown_count++;
      endcase
   endtask

   // Waits until every result is in, then pauses before anything else touches it.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_item_type fixed_item(input logic [1:0] act, input logic kern,
                                               input logic [1:0] caller, input logic is_mod,
                                               input logic [2:0] tpart, input logic [3:0] err,
                                               input logic [7:0] idx);
      req_item_type r;
      r.action           = act;
      r.caller_is_kernel = kern;
      r.caller_part      = caller;
      r.target_is_module = is_mod;
      r.target_part      = tpart;
      r.err_code         = err;
      r.detail           = $urandom;
      r.event_index      = idx;
      r.timestamp_us     = {$urandom, $urandom};
      return r;
   endfunction

   // Random request. Three of four raises and reads are shaped so that they
   // pass the rights and range checks with random content; the rest are
   // left fully random and mostly bounce off those checks.
   function automatic req_item_type make_random();
      req_item_type r;
      int pick;
      r.caller_is_kernel = 1'($urandom);
      r.caller_part      = 2'($urandom);
      r.target_is_module = 1'($urandom);
      r.target_part      = 3'($urandom);
      r.err_code         = 4'($urandom);
      r.detail           = $urandom;
      r.event_index      = 8'($urandom);
      r.timestamp_us     = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.action = ACT_RAISE;
         if ($urandom_range(0, 3) != 0) begin
            r.err_code         = 4'($urandom_range(0, ErrKinds - 1));
            r.target_is_module = ($urandom_range(0, 4) == 0);
            if (r.target_is_module) r.caller_is_kernel = 1'b1;
            if (cur_parts != 0) r.target_part = 3'($urandom_range(0, cur_parts - 1));
            r.caller_part = r.target_part[1:0];
         end
      end else if (pick < 85) begin
         r.action = ACT_READ_EVENT;
         if ($urandom_range(0, 3) != 0) begin
            if (!r.caller_is_kernel) r.caller_part = cur_maint;
            r.event_index = 8'($urandom_range(0, LogDepthDefault - 1));
         end
      end else if (pick < 95) begin
         r.action = ACT_READ_STATS;
      end else begin
         r.action = ACT_UNKNOWN;
      end
      return r;
   endfunction

   // Module and partition words for a random phase: all zeros (log only),
   // all ones (response 7, safe state) or a random mix.
   function automatic logic [23:0] phase_word(input int p);
      if (p == 2) return '0;
      if (p == 4) return '1;
      return 24'($urandom);
   endfunction

   initial begin
      int p;
      int e;
      int n;
      req_item_type r;

      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset nothing is configured: a raise forces safe
      // state with its own code, an event read is refused as a bad
      // parameter, and statistics still answer.
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b0, 3'd0, 4'd15, 8'd0));
      send_request(fixed_item(ACT_READ_EVENT, 1'b1, 2'd0, 1'b0, 3'd0, 4'd0, 8'd0));
      send_request(fixed_item(ACT_READ_STATS, 1'b0, 2'd3, 1'b0, 3'd0, 4'd0, 8'd0));
      send_request(fixed_item(ACT_UNKNOWN, 1'b1, 2'd0, 1'b0, 3'd0, 4'd0, 8'd0));
      settle();

      // Partition 0 and the module map codes 0..7 to responses 0..7, so the
      // codes above safe state are seen to be logged as given but carried
      // out as safe state. Partition 1 always asks for response 7 and
      // partition 2 only logs.
      program_all(1'b1, 3'd4, 2'd2, 24'hFAC688, 24'hFAC688, 24'hFFFFFF, 24'h000000,
                  24'($urandom));
      for (e = 0; e < ErrKinds; e++) begin
         r = fixed_item(ACT_RAISE, 1'b1, 2'($urandom), 1'b0, 3'd0, 4'(e), 8'($urandom));
         if (e == 0) begin
            r.detail       = '0;
            r.timestamp_us = '0;
         end
         if (e == ErrKinds - 1) begin
            r.detail       = '1;
            r.timestamp_us = '1;
         end
         send_request(r);
      end
      // Module fault: logged and carried out, no partition mode touched.
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b1, 3'd0, 4'd5, 8'd0));
      // Error codes past the supported range.
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b0, 3'd0, 4'd8, 8'd0));
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b0, 3'd0, 4'd15, 8'd0));
      // A partition raising against itself is fine; against another
      // partition or against the module it is denied.
      send_request(fixed_item(ACT_RAISE, 1'b0, 2'd1, 1'b0, 3'd1, 4'd3, 8'd0));
      send_request(fixed_item(ACT_RAISE, 1'b0, 2'd1, 1'b0, 3'd2, 4'd3, 8'd0));
      send_request(fixed_item(ACT_RAISE, 1'b0, 2'd3, 1'b1, 3'd3, 4'd3, 8'd0));
      // Targets beyond the partitions in use, then a raise by partition 2 on itself.
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b0, 3'd4, 4'd1, 8'd0));
      send_request(fixed_item(ACT_RAISE, 1'b1, 2'd0, 1'b0, 3'd7, 4'd1, 8'd0));
      send_request(fixed_item(ACT_RAISE, 1'b0, 2'd2, 1'b0, 3'd2, 4'd6, 8'd0));
      // Event reads: kernel, the maintenance partition on the newest entry,
      // a partition without rights, and an index far past the log.
      send_request(fixed_item(ACT_READ_EVENT, 1'b1, 2'd0, 1'b0, 3'd0, 4'd0, 8'd0));
      send_request(fixed_item(ACT_READ_EVENT, 1'b0, 2'd2, 1'b0, 3'd0, 4'd0, 8'd10));
      send_request(fixed_item(ACT_READ_EVENT, 1'b0, 2'd0, 1'b0, 3'd0, 4'd0, 8'd0));
      send_request(fixed_item(ACT_READ_EVENT, 1'b1, 2'd0, 1'b0, 3'd0, 4'd0, 8'd255));
      send_request(fixed_item(ACT_READ_STATS, 1'b1, 2'd0, 1'b0, 3'd0, 4'd0, 8'd0));

      // Random phases. Each one rewrites every register: the partition count
      // goes from none to all four, the maintenance partition walks 0..3,
      // one phase runs unconfigured, and the action words take all zeros,
      // all ones and random values. The log fills within the first phase,
      // after which raises that pass the checks only bump the lost count.
      // The third phase runs with no idle cycles at all.
      for (p = 0; p < 6; p++) begin
         settle();
         program_all(p != 3,
                     (p == 1) ? 3'd0 : (p == 0 || p == 5) ? 3'd4 : 3'($urandom_range(1, 4)),
                     2'(p), phase_word(p), phase_word(p), phase_word(p), phase_word(p),
                     phase_word(p));
         steady = (p == 2);
         for (n = 0; n < 272; n++) send_request(make_random());
      end

      settle();
      repeat (6) @(posedge clock);

      $display("Sent %0d requests: %0d raises, %0d event reads, %0d statistics reads, %0d invalid.",
               raise_count + read_count + stats_count + unknown_count, raise_count, read_count,
               stats_count, unknown_count);
      $display("Compared %0d results under %0d register settings.", checked, settings_used);
      if (pending != 0) $display("%0d expected results never arrived", pending);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### fault_health_monitor_unit.f
rtl/core/fhm_pkg.sv
rtl/core/fhm_csr.sv
rtl/core/fhm_log_mem.sv
rtl/core/fault_health_monitor_unit.sv
rtl/core/fhm_checker.sv
tb/fault_monitor_checker.sv
tb/tb.sv
